// ----- rtl/mrlr_pkg.sv -----
package mrlr_pkg;

	// CRC-16 as used on the serial line: reflected polynomial, all-ones seed
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Slave ID that every unit answers to
	localparam logic [7:0] BCAST_ID = 8'hFF;

	// Function codes
	localparam logic [7:0] FN_READ_HOLDING = 8'h03;
	localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

	// Register addresses that get an answer
	localparam logic [15:0] REG_WEIGHT  = 16'h0001;
	localparam logic [15:0] REG_CAL     = 16'h0009;
	localparam logic [15:0] REG_ID_RATE = 16'h000B;
	localparam logic [15:0] REG_ZERO    = 16'h000D;
	localparam logic [15:0] REG_TARE    = 16'h000F;

	// Byte count field of the weight read answer
	localparam logic [7:0] READ_BYTE_COUNT = 8'h04;

	// Longest canned message before the CRC
	localparam int MSG_MAX = 7;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_DEVICE_ADDRESS = 2'd0,
		CFG_WEIGHT_STEP    = 2'd1,
		CFG_ID_RATE_VALUE  = 2'd2
	} cfg_index_t;

	// Fold one byte into a running CRC, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/mrlr_rx_if.sv -----
interface mrlr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source (output valid, output rx_byte, output frame_end, input ready);
	modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ----- rtl/mrlr_tx_if.sv -----
interface mrlr_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;

	modport source (output valid, output tx_byte, output last_byte, input ready);
	modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

// ----- rtl/modbus_rtu_loadcell_responder.sv -----
// Modbus RTU slave for an emulated load cell. Received bytes enter on rx, one per
// transaction, with frame_end on the last byte; a frame also closes by itself at
// FRAME_MAX bytes. Frames that are short, addressed elsewhere or fail the CRC are
// dropped silently. Accepted requests for a known function and register produce a
// canned answer (8 or 9 bytes, CRC low byte first) on tx, last_byte on the final
// byte. The frame check and the answer selection are done in the same cycle as the
// closing byte is taken. The answer is sent one byte per cycle while tx is ready, from
// a message buffer, its CRC folded in byte by byte as it goes out. While an answer
// is still in the buffer, mid-frame bytes keep being taken, but a byte that would
// close another frame waits until the last answer byte has moved to the output
// register. Configuration is written through cfg_we / cfg_index / cfg_data.
module modbus_rtu_loadcell_responder
	import mrlr_pkg::*;
#(
	parameter int FRAME_MAX = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	mrlr_rx_if.sink          rx,
	mrlr_tx_if.source        tx
);

	localparam int CNT_W = $clog2(FRAME_MAX + 1);

	// Configuration registers
	logic [7:0]  device_address_q;
	logic [15:0] weight_step_q;
	logic [7:0]  id_rate_value_q;

	// Frame state
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       header_q [4];
	logic [15:0]      crc_q;
	logic [15:0]      tail_q;
	logic [15:0]      weight_q;

	// Answer buffer and sender
	logic [7:0]  msg_q [MSG_MAX];
	logic [2:0]  msg_len_q;
	logic [3:0]  idx_q;
	logic        busy_q;
	logic [15:0] tx_crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	// Input side combinational signals
	logic             in_take;
	logic [CNT_W-1:0] count_inc;
	logic             closes;
	logic [7:0]       hdr_n [4];
	logic [15:0]      crc_n;
	logic [15:0]      rx_crc;
	logic             frame_ok;
	logic [15:0]      req_reg;
	logic [7:0]       msg_n [MSG_MAX];
	logic [2:0]       len_n;
	logic             answer;
	logic             weight_read;

	// Sender combinational signals
	logic       load;
	logic [7:0] next_byte;
	logic       next_last;
	logic       next_is_msg;

	// Frame bookkeeping for the byte on the input
	assign count_inc = byte_count_q + 1'b1;
	assign closes    = rx.frame_end || (count_inc >= CNT_W'(FRAME_MAX));

	// Hold back a closing byte while an answer is still queued
	assign rx.ready = !(busy_q && closes);
	assign in_take  = rx.valid && rx.ready;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hdr_n[i] = header_q[i];
		end
		if (byte_count_q < CNT_W'(4)) begin
			hdr_n[byte_count_q[1:0]] = rx.rx_byte;
		end
	end

	// CRC runs two bytes behind: the byte leaving the tail window is folded in
	assign crc_n = (byte_count_q >= CNT_W'(2)) ? crc16_byte(crc_q, tail_q[15:8]) : crc_q;
	assign rx_crc = {rx.rx_byte, tail_q[7:0]};

	assign frame_ok = (count_inc >= CNT_W'(4))
		&& ((hdr_n[0] == device_address_q) || (hdr_n[0] == BCAST_ID))
		&& (crc_n == rx_crc);

	assign req_reg = {hdr_n[2], hdr_n[3]};

	// Select the canned answer
	always_comb begin
		answer      = 1'b0;
		weight_read = 1'b0;
		len_n       = 3'd6;
		msg_n[0]    = device_address_q;
		msg_n[1]    = FN_WRITE_MULTI;
		msg_n[2]    = 8'h00;
		msg_n[3]    = 8'h00;
		msg_n[4]    = 8'h00;
		msg_n[5]    = 8'h02;
		msg_n[6]    = 8'h00;
		if (hdr_n[1] == FN_READ_HOLDING) begin
			if (req_reg == REG_WEIGHT) begin
				answer      = 1'b1;
				weight_read = 1'b1;
				len_n       = 3'd7;
				msg_n[1]    = FN_READ_HOLDING;
				msg_n[2]    = READ_BYTE_COUNT;
				msg_n[3]    = 8'h01;
				msg_n[4]    = 8'h30;
				msg_n[5]    = weight_q[15:8];
				msg_n[6]    = weight_q[7:0];
			end
		end else if (hdr_n[1] == FN_WRITE_MULTI) begin
			case (req_reg)
				REG_WEIGHT: begin
					answer   = 1'b1;
					msg_n[3] = 8'h01;
				end
				REG_CAL: begin
					answer   = 1'b1;
					msg_n[3] = 8'h09;
				end
				REG_ID_RATE: begin
					answer   = 1'b1;
					len_n    = 3'd7;
					msg_n[2] = 8'h04;
					msg_n[3] = 8'h0F;
					msg_n[5] = 8'h00;
					msg_n[6] = id_rate_value_q;
				end
				REG_ZERO, REG_TARE: begin
					answer   = 1'b1;
					msg_n[3] = 8'h0F;
				end
				default: begin
					answer = 1'b0;
				end
			endcase
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 8'd1;
			weight_step_q    <= 16'd1000;
			id_rate_value_q  <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data[7:0];
				CFG_WEIGHT_STEP:    weight_step_q    <= cfg_data;
				CFG_ID_RATE_VALUE:  id_rate_value_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Advance the frame state; clear it when a frame closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			crc_q        <= CRC_INIT;
			tail_q       <= '0;
			weight_q     <= '0;
			for (int i = 0; i < 4; i++) begin
				header_q[i] <= '0;
			end
		end else if (in_take) begin
			if (closes) begin
				byte_count_q <= '0;
				crc_q        <= CRC_INIT;
				tail_q       <= '0;
				for (int i = 0; i < 4; i++) begin
					header_q[i] <= '0;
				end
				if (frame_ok && answer && weight_read) begin
					weight_q <= weight_q + weight_step_q;
				end
			end else begin
				byte_count_q <= count_inc;
				crc_q        <= crc_n;
				tail_q       <= {tail_q[7:0], rx.rx_byte};
				for (int i = 0; i < 4; i++) begin
					header_q[i] <= hdr_n[i];
				end
			end
		end
	end

	// Pick the next byte to send: message, then CRC low, then CRC high
	assign next_is_msg = idx_q < {1'b0, msg_len_q};
	always_comb begin
		next_last = 1'b0;
		if (next_is_msg) begin
			next_byte = msg_q[idx_q[2:0]];
		end else if (idx_q == {1'b0, msg_len_q}) begin
			next_byte = tx_crc_q[7:0];
		end else begin
			next_byte = tx_crc_q[15:8];
			next_last = 1'b1;
		end
	end

	assign load = busy_q && (!out_valid_q || tx.ready);

	// Answer buffer: fill on an accepted frame, drain one byte per load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			tx_crc_q <= CRC_INIT;
		end else if (in_take && closes && frame_ok && answer) begin
			busy_q   <= 1'b1;
			idx_q    <= '0;
			tx_crc_q <= CRC_INIT;
		end else if (load) begin
			idx_q <= idx_q + 1'b1;
			if (next_is_msg) begin
				tx_crc_q <= crc16_byte(tx_crc_q, next_byte);
			end
			if (next_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Message payload
	always_ff @(posedge clk) begin
		if (in_take && closes && frame_ok && answer) begin
			msg_len_q <= len_n;
			for (int i = 0; i < MSG_MAX; i++) begin
				msg_q[i] <= msg_n[i];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			out_last_q <= next_last;
		end
	end

	assign tx.valid     = out_valid_q;
	assign tx.tx_byte   = out_byte_q;
	assign tx.last_byte = out_last_q;

endmodule
